[hdl/lps_pkg.sv]
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and constants for the line pixel stepper.
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int COORD_W     = 12;   // signed endpoint coordinate
    localparam int SPAN_W      = 13;   // unsigned span
    localparam int ERR_W       = 15;   // signed error term
    localparam int COLOR_W     = 16;
    localparam int ADDR_W      = 19;
    localparam int FRAME_IDX_W = 11;   // frame dimensions stay below 2048
    localparam int PROD_W      = 2 * FRAME_IDX_W;

    localparam int DEF_FRAME_WIDTH  = 640;
    localparam int DEF_FRAME_HEIGHT = 480;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    // classified word: endpoints already ordered along the major axis
    typedef struct packed {
        logic                       mode;
        logic                       steep;
        logic signed [COORD_W-1:0]  a0;     // major start
        logic signed [COORD_W-1:0]  a1;     // major end
        logic signed [COORD_W-1:0]  b0;     // minor start
        logic signed [COORD_W-1:0]  b1;     // minor end
        logic        [COLOR_W-1:0]  color;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

[hdl/lps_front.sv]
// ----------------------------------------------------------------------------
// lps_front
// Classifies an incoming word: picks the major axis and orders the endpoints
// so the major coordinate rises.
// ----------------------------------------------------------------------------
module lps_front
    import lps_pkg::*;
(
    input  logic                       i_mode,
    input  logic signed [COORD_W-1:0]  i_start_x,
    input  logic signed [COORD_W-1:0]  i_start_y,
    input  logic signed [COORD_W-1:0]  i_end_x,
    input  logic signed [COORD_W-1:0]  i_end_y,
    input  logic        [COLOR_W-1:0]  i_pen_color,
    output t_cmd                       o_cmd
);

    logic signed [SPAN_W-1:0]  dx, dy;
    logic        [SPAN_W-1:0]  adx, ady;
    logic                      steep;
    logic signed [COORD_W-1:0] a0, a1, b0, b1;
    logic                      swap;

    always_comb begin
        dx  = SPAN_W'($signed(i_end_x)) - SPAN_W'($signed(i_start_x));
        dy  = SPAN_W'($signed(i_end_y)) - SPAN_W'($signed(i_start_y));
        adx = dx[SPAN_W-1] ? SPAN_W'(-dx) : SPAN_W'(dx);
        ady = dy[SPAN_W-1] ? SPAN_W'(-dy) : SPAN_W'(dy);
        steep = ady > adx;

        if (steep) begin
            a0 = i_start_y; b0 = i_start_x; a1 = i_end_y; b1 = i_end_x;
        end else begin
            a0 = i_start_x; b0 = i_start_y; a1 = i_end_x; b1 = i_end_y;
        end
        swap = a0 > a1;

        o_cmd.mode  = i_mode;
        o_cmd.steep = steep;
        o_cmd.a0    = swap ? a1 : a0;
        o_cmd.a1    = swap ? a0 : a1;
        o_cmd.b0    = swap ? b1 : b0;
        o_cmd.b1    = swap ? b0 : b1;
        o_cmd.color = i_pen_color;
    end

endmodule

[hdl/lps_queue.sv]
// ----------------------------------------------------------------------------
// lps_queue
// Short FIFO between the classifier and the stepping engine.
// ----------------------------------------------------------------------------
module lps_queue
    import lps_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cmd   i_data,
    input  logic   i_pop,
    output t_cmd   o_data,
    output t_qstat o_stat
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (32'(p) == QUEUE_DEPTH - 1) ? '0 : QPTR_W'(p + 1'b1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push)
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (i_pop)
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            if (i_push && !i_pop)
                r_count <= QCNT_W'(r_count + 1'b1);
            else if (i_pop && !i_push)
                r_count <= QCNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_data;
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (32'(r_count) == QUEUE_DEPTH);
    assign o_stat.empty = (r_count == '0);

endmodule

[hdl/lps_back.sv]
// ----------------------------------------------------------------------------
// lps_back
// Stepping engine: loads the active line on a load word, runs one Bresenham
// step per step word while a line is active, and registers the result word.
// ----------------------------------------------------------------------------
module lps_back
    import lps_pkg::*;
#(
    parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic                i_cmd_valid,
    output logic                o_cmd_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_pixel_valid,
    output logic [ADDR_W-1:0]   o_pixel_addr,
    output logic [COLOR_W-1:0]  o_pixel_color,
    output logic                o_line_done
);

    localparam logic [FRAME_IDX_W-1:0] FW     = FRAME_IDX_W'(FRAME_WIDTH);
    localparam logic [FRAME_IDX_W-1:0] FH     = FRAME_IDX_W'(FRAME_HEIGHT);
    localparam logic [PROD_W-1:0]      FW_EXT = PROD_W'(FRAME_WIDTH);

    // line state
    logic signed [COORD_W-1:0] r_major_pos, n_major_pos;
    logic signed [COORD_W-1:0] r_major_end, n_major_end;
    logic signed [COORD_W-1:0] r_minor_pos, n_minor_pos;
    logic        [SPAN_W-1:0]  r_major_span, n_major_span;
    logic        [SPAN_W-1:0]  r_minor_span, n_minor_span;
    logic signed [ERR_W-1:0]   r_error_acc, n_error_acc;
    logic                      r_minor_dir_neg, n_minor_dir_neg;
    logic                      r_axis_steep, n_axis_steep;
    logic        [COLOR_W-1:0] r_line_color, n_line_color;
    logic                      r_busy, n_busy;

    // output word
    logic                r_out_valid;
    logic                r_pix_valid, n_pix_valid;
    logic [ADDR_W-1:0]   r_pix_addr, n_pix_addr;
    logic [COLOR_W-1:0]  r_pix_color, n_pix_color;
    logic                r_done, n_done;

    logic                      take;
    logic signed [COORD_W-1:0] px, py;
    logic                      in_frame;
    logic [PROD_W-1:0]         addr_full;
    logic signed [SPAN_W-1:0]  db;
    logic signed [ERR_W:0]     err_sum;
    logic                      err_wrap;
    logic signed [COORD_W-1:0] major_inc;

    assign take      = i_cmd_valid && (!r_out_valid || i_ready);
    assign o_cmd_pop = take;

    always_comb begin
        n_major_pos     = r_major_pos;
        n_major_end     = r_major_end;
        n_minor_pos     = r_minor_pos;
        n_major_span    = r_major_span;
        n_minor_span    = r_minor_span;
        n_error_acc     = r_error_acc;
        n_minor_dir_neg = r_minor_dir_neg;
        n_axis_steep    = r_axis_steep;
        n_line_color    = r_line_color;
        n_busy          = r_busy;
        n_pix_valid     = 1'b0;
        n_pix_addr      = '0;
        n_pix_color     = '0;
        n_done          = 1'b1;

        px        = r_axis_steep ? r_minor_pos : r_major_pos;
        py        = r_axis_steep ? r_major_pos : r_minor_pos;
        in_frame  = !px[COORD_W-1] && !py[COORD_W-1]
                    && (px[FRAME_IDX_W-1:0] < FW) && (py[FRAME_IDX_W-1:0] < FH);
        addr_full = FW_EXT * {{(PROD_W-FRAME_IDX_W){1'b0}}, py[FRAME_IDX_W-1:0]}
                    + {{(PROD_W-FRAME_IDX_W){1'b0}}, px[FRAME_IDX_W-1:0]};
        // error step: wrap when twice the sum exceeds the major span
        err_sum   = (ERR_W+1)'(r_error_acc) + $signed({3'b000, r_minor_span});
        err_wrap  = $signed({err_sum, 1'b0}) > $signed({4'b0000, r_major_span});
        major_inc = COORD_W'(r_major_pos + 2'sd1);
        db        = SPAN_W'($signed(i_cmd.b1)) - SPAN_W'($signed(i_cmd.b0));

        if (i_cmd.mode == MODE_LOAD) begin
            n_major_pos     = i_cmd.a0;
            n_major_end     = i_cmd.a1;
            n_minor_pos     = i_cmd.b0;
            n_major_span    = SPAN_W'(SPAN_W'($signed(i_cmd.a1))
                                      - SPAN_W'($signed(i_cmd.a0)));
            n_minor_span    = db[SPAN_W-1] ? SPAN_W'(-db) : SPAN_W'(db);
            n_minor_dir_neg = !(i_cmd.b0 < i_cmd.b1);
            n_axis_steep    = i_cmd.steep;
            n_error_acc     = '0;
            n_line_color    = i_cmd.color;
            n_busy          = (i_cmd.a0 != i_cmd.a1);
            n_done          = !n_busy;
        end else if (r_busy) begin
            n_pix_valid = in_frame;
            n_pix_addr  = in_frame ? addr_full[ADDR_W-1:0] : '0;
            n_pix_color = in_frame ? r_line_color : '0;
            if (err_wrap) begin
                n_minor_pos = r_minor_dir_neg ? COORD_W'(r_minor_pos - 2'sd1)
                                              : COORD_W'(r_minor_pos + 2'sd1);
                n_error_acc = ERR_W'(err_sum - $signed({3'b000, r_major_span}));
            end else begin
                n_error_acc = ERR_W'(err_sum);
            end
            n_major_pos = major_inc;
            n_busy      = (major_inc != r_major_end);
            n_done      = !n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major_pos     <= '0;
            r_major_end     <= '0;
            r_minor_pos     <= '0;
            r_major_span    <= '0;
            r_minor_span    <= '0;
            r_error_acc     <= '0;
            r_minor_dir_neg <= 1'b0;
            r_axis_steep    <= 1'b0;
            r_line_color    <= '0;
            r_busy          <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (take) begin
                r_major_pos     <= n_major_pos;
                r_major_end     <= n_major_end;
                r_minor_pos     <= n_minor_pos;
                r_major_span    <= n_major_span;
                r_minor_span    <= n_minor_span;
                r_error_acc     <= n_error_acc;
                r_minor_dir_neg <= n_minor_dir_neg;
                r_axis_steep    <= n_axis_steep;
                r_line_color    <= n_line_color;
                r_busy          <= n_busy;
                r_out_valid     <= 1'b1;
            end else if (i_ready) begin
                r_out_valid     <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pix_valid <= n_pix_valid;
            r_pix_addr  <= n_pix_addr;
            r_pix_color <= n_pix_color;
            r_done      <= n_done;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_valid = r_pix_valid;
    assign o_pixel_addr  = r_pix_addr;
    assign o_pixel_color = r_pix_color;
    assign o_line_done   = r_done;

endmodule

[hdl/line_pixel_stepper.sv]
// ----------------------------------------------------------------------------
// line_pixel_stepper
// Result path: the accepted input word is written into the queue, then the
// result word is registered in the stepping engine's output register.
// Throughput: one word per cycle while the output is not stalled; the
// stepping engine's error/minor update is combinational, and a 2-entry
// queue decouples the sides.
// o_ready drops only when the output stalls and the queue holds 2 words.
// Reset (i_rst_n low, synchronous) clears line state, queue and output valid.
// ----------------------------------------------------------------------------
module line_pixel_stepper
    import lps_pkg::*;
#(
    parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_mode,
    input  logic signed [COORD_W-1:0]  i_start_x,
    input  logic signed [COORD_W-1:0]  i_start_y,
    input  logic signed [COORD_W-1:0]  i_end_x,
    input  logic signed [COORD_W-1:0]  i_end_y,
    input  logic        [COLOR_W-1:0]  i_pen_color,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_pixel_valid,
    output logic        [ADDR_W-1:0]   o_pixel_addr,
    output logic        [COLOR_W-1:0]  o_pixel_color,
    output logic                       o_line_done
);

    t_cmd   front_cmd, q_cmd;
    t_qstat q_stat;
    logic   q_push, q_pop;

    lps_front u_front (
        .i_mode      (i_mode),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .i_pen_color (i_pen_color),
        .o_cmd       (front_cmd)
    );

    assign o_ready = !q_stat.full;
    assign q_push  = i_valid && o_ready;

    lps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_cmd),
        .i_pop   (q_pop),
        .o_data  (q_cmd),
        .o_stat  (q_stat)
    );

    lps_back #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (q_cmd),
        .i_cmd_valid   (!q_stat.empty),
        .o_cmd_pop     (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_valid (o_pixel_valid),
        .o_pixel_addr  (o_pixel_addr),
        .o_pixel_color (o_pixel_color),
        .o_line_done   (o_line_done)
    );

    // no result word appears without a queued word behind it
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_stat.empty && !q_push && !(o_valid && !i_ready)) |=> !o_valid)
        else $error("result word without a source word");

    // suppressed pixels carry zero address and color
    a_suppressed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_pixel_valid) |-> (o_pixel_addr == '0 && o_pixel_color == '0))
        else $error("suppressed pixel with nonzero payload");

    // emitted pixel lies inside the frame (checked when the frame fits ADDR_W)
    a_addr_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pixel_valid) |->
            ((FRAME_WIDTH * FRAME_HEIGHT > (1 << ADDR_W))
             || (32'(o_pixel_addr) < FRAME_WIDTH * FRAME_HEIGHT)))
        else $error("pixel address outside frame");

    // pop only from a non-empty queue, push only into a non-full one
    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_stat.empty) && !(q_push && q_stat.full))
        else $error("queue overflow or underflow");

endmodule
